@@ rtl/msd_pkg.sv @@
// Shared types, field layout and codes for the microprogrammed stack datapath.
package msd_pkg;

   localparam int unsigned MEM_BYTES_DEF = 65536;
   localparam int unsigned CONTROL_WORDS = 512;
   localparam int unsigned CS_AW         = $clog2(CONTROL_WORDS);
   localparam int unsigned CS_WIDTH      = 36;
   localparam int unsigned NUM_REGS      = 9;
   localparam int unsigned WORD_BYTES    = 4;

   // request opcodes
   localparam logic [1:0] OP_LOAD_CS  = 2'd0;
   localparam logic [1:0] OP_LOAD_MEM = 2'd1;
   localparam logic [1:0] OP_EXEC     = 2'd2;

   // word register file slots, also C mask bit positions
   localparam int unsigned IDX_MAR = 0;
   localparam int unsigned IDX_MDR = 1;
   localparam int unsigned IDX_PC  = 2;
   localparam int unsigned IDX_SP  = 3;
   localparam int unsigned IDX_LV  = 4;
   localparam int unsigned IDX_CPP = 5;
   localparam int unsigned IDX_TOS = 6;
   localparam int unsigned IDX_OPC = 7;
   localparam int unsigned IDX_H   = 8;

   // B bus sources
   localparam logic [3:0] BSRC_MDR  = 4'd0;
   localparam logic [3:0] BSRC_PC   = 4'd1;
   localparam logic [3:0] BSRC_MBRS = 4'd2;
   localparam logic [3:0] BSRC_MBRU = 4'd3;
   localparam logic [3:0] BSRC_SP   = 4'd4;
   localparam logic [3:0] BSRC_LV   = 4'd5;
   localparam logic [3:0] BSRC_CPP  = 4'd6;
   localparam logic [3:0] BSRC_TOS  = 4'd7;
   localparam logic [3:0] BSRC_OPC  = 4'd8;

   // shifter codes
   localparam logic [1:0] SH_SLL8 = 2'd1;
   localparam logic [1:0] SH_SRA1 = 2'd2;

   // ALU function select (F0 F1)
   localparam logic [1:0] FN_AND = 2'd0;
   localparam logic [1:0] FN_OR  = 2'd1;
   localparam logic [1:0] FN_NOTB = 2'd2;

   typedef struct packed {
      logic [8:0] next_addr;
      logic [2:0] jump;
      logic [1:0] shift;
      logic [5:0] alu;
      logic [8:0] cmask;
      logic [2:0] mem;
      logic [3:0] bsel;
   } mir_type;

   typedef logic [NUM_REGS-1:0][31:0] word_regs_type;

endpackage

@@ rtl/microprogrammed_stack_datapath_step.sv @@
// Top level: microprogrammed stack datapath with control store and main memory in RAM.
// Execute word: control store read, ALU and register write, then an optional byte fetch
//   and word read or write, each address first reduced in the modulo unit, then the result.
// Load control store word: written from the request buffer. Load memory byte: reduced, then written.
// Words are taken while an earlier one is in flight; one waits in the request buffer.
// Reset: a clearing pass over every main memory address zeroes main memory and the control store;
//   requests are stalled until it ends. Registers, MPC, MIR and flags clear at once.
module microprogrammed_stack_datapath_step import msd_pkg::*; #(
   parameter int unsigned MEM_BYTES = MEM_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [15:0] req_address,
   input  logic [35:0] req_load_data,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [8:0]  rsp_next_micro_address,
   output logic [31:0] rsp_mar_value,
   output logic [31:0] rsp_mdr_value,
   output logic [31:0] rsp_pc_value,
   output logic [7:0]  rsp_mbr_value,
   output logic [31:0] rsp_sp_value,
   output logic [31:0] rsp_lv_value,
   output logic [31:0] rsp_cpp_value,
   output logic [31:0] rsp_tos_value,
   output logic [31:0] rsp_opc_value,
   output logic [31:0] rsp_h_value,
   output logic [1:0]  rsp_alu_flags
);

   localparam int unsigned AW = $clog2(MEM_BYTES);

   // sequencer states
   localparam logic [3:0] ST_CLEAR     = 4'd0;
   localparam logic [3:0] ST_IDLE      = 4'd1;
   localparam logic [3:0] ST_LOAD_MOD  = 4'd2;
   localparam logic [3:0] ST_ALU       = 4'd3;
   localparam logic [3:0] ST_FETCH_MOD = 4'd4;
   localparam logic [3:0] ST_FETCH_RD  = 4'd5;
   localparam logic [3:0] ST_WORD_MOD  = 4'd6;
   localparam logic [3:0] ST_WORD_RD   = 4'd7;
   localparam logic [3:0] ST_WORD_WR   = 4'd8;
   localparam logic [3:0] ST_FINISH    = 4'd9;

   logic [3:0] state_ff, state_in;

   // request buffer
   logic        buf_valid_ff, buf_valid_in;
   logic [1:0]  buf_opcode_ff, buf_opcode_in;
   logic [15:0] buf_address_ff, buf_address_in;
   logic [35:0] buf_data_ff, buf_data_in;
   logic        buf_pop;

   // architectural state
   word_regs_type regs_ff, regs_in;
   logic [7:0]    mbr_ff, mbr_in;
   logic [8:0]    mpc_ff, mpc_in;
   mir_type       mir_ff, mir_in;
   logic [1:0]    flags_ff, flags_in;

   // sequencing scratch
   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [2:0]    cnt_ff, cnt_in;
   logic [7:0]    byte_ff, byte_in;

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [8:0]    rsp_mpc_ff, rsp_mpc_in;
   word_regs_type rsp_regs_ff, rsp_regs_in;
   logic [7:0]    rsp_mbr_ff, rsp_mbr_in;
   logic [1:0]    rsp_flags_ff, rsp_flags_in;
   logic          out_free;

   // memories and shared units
   logic                 cs_en, cs_we;
   logic [CS_AW-1:0]     cs_addr;
   logic [CS_WIDTH-1:0]  cs_wdata, cs_rdata;
   logic                 mm_en, mm_we;
   logic [AW-1:0]        mm_addr;
   logic [7:0]           mm_wdata, mm_rdata;
   logic                 mod_start, mod_done;
   logic [31:0]          mod_value;
   logic [AW-1:0]        mod_result;

   mir_type       mir_now;
   word_regs_type regs_alu;
   logic [31:0]   alu_result;
   logic [1:0]    alu_flags;
   logic [AW-1:0] addr_next;
   logic [8:0]    mpc_next;

   msd_ram #(.WIDTH(CS_WIDTH), .DEPTH(CONTROL_WORDS)) u_cstore (
      .clock (clock),
      .en    (cs_en),
      .we    (cs_we),
      .addr  (cs_addr),
      .wdata (cs_wdata),
      .rdata (cs_rdata)
   );

   msd_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mainmem (
      .clock (clock),
      .en    (mm_en),
      .we    (mm_we),
      .addr  (mm_addr),
      .wdata (mm_wdata),
      .rdata (mm_rdata)
   );

   msd_modu #(.MODULUS(MEM_BYTES)) u_modu (
      .clock  (clock),
      .reset  (reset),
      .start  (mod_start),
      .value  (mod_value),
      .done   (mod_done),
      .result (mod_result)
   );

   assign mir_now = mir_type'(cs_rdata);

   msd_alu u_alu (
      .mir    (mir_now),
      .regs   (regs_ff),
      .mbr    (mbr_ff),
      .result (alu_result),
      .flags  (alu_flags)
   );

   always_comb begin
      // C bus write, independent per register
      for (int k = 0; k < NUM_REGS; k++) begin
         regs_alu[k] = mir_now.cmask[k] ? alu_result : regs_ff[k];
      end

      // word accesses wrap at the top of memory
      addr_next = (addr_ff == AW'(MEM_BYTES - 1)) ? '0 : addr_ff + AW'(1);

      // jump logic: the zero or nonzero flag into bit 8, MBR into the low byte
      mpc_next = mir_ff.next_addr;
      if (mir_ff.jump[0]) begin
         mpc_next[8] = mpc_next[8] | flags_ff[0];
      end
      if (mir_ff.jump[1]) begin
         mpc_next[8] = mpc_next[8] | flags_ff[1];
      end
      if (mir_ff.jump[2]) begin
         mpc_next[7:0] = mpc_next[7:0] | mbr_ff;
      end
   end

   assign buf_pop   = (state_ff == ST_IDLE) && buf_valid_ff;
   assign req_stall = (state_ff == ST_CLEAR) || (buf_valid_ff && !buf_pop);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in       = state_ff;
      buf_valid_in   = buf_valid_ff;
      buf_opcode_in  = buf_opcode_ff;
      buf_address_in = buf_address_ff;
      buf_data_in    = buf_data_ff;
      regs_in        = regs_ff;
      mbr_in         = mbr_ff;
      mpc_in         = mpc_ff;
      mir_in         = mir_ff;
      flags_in       = flags_ff;
      clr_cnt_in     = clr_cnt_ff;
      addr_in        = addr_ff;
      cnt_in         = cnt_ff;
      byte_in        = byte_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_mpc_in     = rsp_mpc_ff;
      rsp_regs_in    = rsp_regs_ff;
      rsp_mbr_in     = rsp_mbr_ff;
      rsp_flags_in   = rsp_flags_ff;

      cs_en     = 1'b0;
      cs_we     = 1'b0;
      cs_addr   = mpc_ff;
      cs_wdata  = buf_data_ff;
      mm_en     = 1'b0;
      mm_we     = 1'b0;
      mm_addr   = addr_ff;
      mm_wdata  = byte_ff;
      mod_start = 1'b0;
      mod_value = {regs_alu[IDX_MAR][29:0], 2'b00};

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // request buffer
      if (buf_pop) begin
         buf_valid_in = 1'b0;
      end
      if (req_valid && !req_stall) begin
         buf_valid_in   = 1'b1;
         buf_opcode_in  = req_opcode;
         buf_address_in = req_address;
         buf_data_in    = req_load_data;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            cs_en      = (clr_cnt_ff < AW'(CONTROL_WORDS));
            cs_we      = 1'b1;
            cs_addr    = clr_cnt_ff[CS_AW-1:0];
            cs_wdata   = '0;
            mm_en      = 1'b1;
            mm_we      = 1'b1;
            mm_addr    = clr_cnt_ff;
            mm_wdata   = 8'b0;
            clr_cnt_in = clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == AW'(MEM_BYTES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (buf_valid_ff) begin
               unique case (buf_opcode_ff)
                  OP_LOAD_CS: begin
                     cs_en   = 1'b1;
                     cs_we   = 1'b1;
                     cs_addr = buf_address_ff[CS_AW-1:0];
                  end
                  OP_LOAD_MEM: begin
                     mod_start = 1'b1;
                     mod_value = {16'b0, buf_address_ff};
                     byte_in   = buf_data_ff[7:0];
                     state_in  = ST_LOAD_MOD;
                  end
                  OP_EXEC: begin
                     cs_en    = 1'b1;
                     state_in = ST_ALU;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_LOAD_MOD: begin
            if (mod_done) begin
               mm_en    = 1'b1;
               mm_we    = 1'b1;
               mm_addr  = mod_result;
               state_in = ST_IDLE;
            end
         end
         ST_ALU: begin
            mir_in   = mir_now;
            regs_in  = regs_alu;
            flags_in = alu_flags;
            if (mir_now.mem[0]) begin
               mod_start = 1'b1;
               mod_value = regs_alu[IDX_PC];
               state_in  = ST_FETCH_MOD;
            end else if (mir_now.mem[1] || mir_now.mem[2]) begin
               mod_start = 1'b1;
               state_in  = ST_WORD_MOD;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FETCH_MOD: begin
            if (mod_done) begin
               mm_en    = 1'b1;
               mm_addr  = mod_result;
               state_in = ST_FETCH_RD;
            end
         end
         ST_FETCH_RD: begin
            mbr_in    = mm_rdata;
            mod_value = {regs_ff[IDX_MAR][29:0], 2'b00};
            if (mir_ff.mem[1] || mir_ff.mem[2]) begin
               mod_start = 1'b1;
               state_in  = ST_WORD_MOD;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_WORD_MOD: begin
            if (mod_done) begin
               addr_in  = mod_result;
               cnt_in   = 3'd0;
               // read with write set writes back what was read: skip the write
               state_in = mir_ff.mem[1] ? ST_WORD_RD : ST_WORD_WR;
            end
         end
         ST_WORD_RD: begin
            if (cnt_ff < 3'(WORD_BYTES)) begin
               mm_en   = 1'b1;
               addr_in = addr_next;
            end
            if (cnt_ff != 3'd0) begin
               regs_in[IDX_MDR] = {mm_rdata, regs_ff[IDX_MDR][31:8]};
            end
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'(WORD_BYTES)) begin
               state_in = ST_FINISH;
            end
         end
         ST_WORD_WR: begin
            mm_en    = 1'b1;
            mm_we    = 1'b1;
            mm_wdata = regs_ff[IDX_MDR][{cnt_ff[1:0], 3'b000} +: 8];
            addr_in  = addr_next;
            cnt_in   = cnt_ff + 3'd1;
            if (cnt_ff == 3'(WORD_BYTES - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               mpc_in       = mpc_next;
               rsp_valid_in = 1'b1;
               rsp_mpc_in   = mpc_next;
               rsp_regs_in  = regs_ff;
               rsp_mbr_in   = mbr_ff;
               rsp_flags_in = flags_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         buf_valid_ff <= 1'b0;
         regs_ff      <= '0;
         mbr_ff       <= 8'b0;
         mpc_ff       <= 9'b0;
         mir_ff       <= '0;
         flags_ff     <= 2'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         buf_valid_ff <= buf_valid_in;
         regs_ff      <= regs_in;
         mbr_ff       <= mbr_in;
         mpc_ff       <= mpc_in;
         mir_ff       <= mir_in;
         flags_ff     <= flags_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_opcode_ff  <= buf_opcode_in;
      buf_address_ff <= buf_address_in;
      buf_data_ff    <= buf_data_in;
      addr_ff        <= addr_in;
      cnt_ff         <= cnt_in;
      byte_ff        <= byte_in;
      rsp_mpc_ff     <= rsp_mpc_in;
      rsp_regs_ff    <= rsp_regs_in;
      rsp_mbr_ff     <= rsp_mbr_in;
      rsp_flags_ff   <= rsp_flags_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_next_micro_address = rsp_mpc_ff;
   assign rsp_mar_value          = rsp_regs_ff[IDX_MAR];
   assign rsp_mdr_value          = rsp_regs_ff[IDX_MDR];
   assign rsp_pc_value           = rsp_regs_ff[IDX_PC];
   assign rsp_mbr_value          = rsp_mbr_ff;
   assign rsp_sp_value           = rsp_regs_ff[IDX_SP];
   assign rsp_lv_value           = rsp_regs_ff[IDX_LV];
   assign rsp_cpp_value          = rsp_regs_ff[IDX_CPP];
   assign rsp_tos_value          = rsp_regs_ff[IDX_TOS];
   assign rsp_opc_value          = rsp_regs_ff[IDX_OPC];
   assign rsp_h_value            = rsp_regs_ff[IDX_H];
   assign rsp_alu_flags          = rsp_flags_ff;

   // reduced addresses always land inside main memory
   a_mod_range: assert property (@(posedge clock) disable iff (reset)
      mod_done |-> ({1'b0, mod_result} < (AW+1)'(MEM_BYTES)))
      else $error("modulo unit result out of range");

   // a new result only ever comes out of the finishing state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FINISH))
      else $error("result raised outside the finishing state");

   // nothing is buffered while the clearing pass runs
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !buf_valid_ff)
      else $error("request taken during clearing pass");

   // the byte counter of a word access never runs past the last byte
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_WORD_RD) || (state_ff == ST_WORD_WR)) |-> (cnt_ff <= 3'(WORD_BYTES)))
      else $error("word access byte counter overran");

endmodule

@@ rtl/msd_ram.sv @@
// Generic single-port synchronous RAM with registered read data.
module msd_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2048,
   localparam int unsigned AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             en,
   input  logic             we,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/msd_modu.sv @@
// Three-stage reduction of a 32-bit byte address modulo the memory size.
module msd_modu import msd_pkg::*; #(
   parameter int unsigned MODULUS = MEM_BYTES_DEF,
   localparam int unsigned AW = $clog2(MODULUS)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [31:0]   value,
   output logic          done,
   output logic [AW-1:0] result
);

   localparam bit IS_POW2 = ((MODULUS & (MODULUS - 1)) == 0);

   logic v1_ff, v2_ff, v3_ff;
   logic [AW-1:0] res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   generate
      if (IS_POW2) begin : g_mask
         logic [AW-1:0] s1_ff, s2_ff;
         always_ff @(posedge clock) begin
            s1_ff  <= value[AW-1:0];
            s2_ff  <= s1_ff;
            res_ff <= s2_ff;
         end
      end else begin : g_recip
         // floor(2^SHIFT / MODULUS) underestimates the quotient by at most one
         localparam int unsigned FLOG  = AW - 1;
         localparam int unsigned SHIFT = 32 + FLOG;
         localparam int unsigned QW    = 32 - FLOG;
         localparam logic [63:0] RECIP_W = (64'd1 << SHIFT) / 64'(MODULUS);
         localparam logic [31:0] RECIP   = RECIP_W[31:0];

         logic [63:0]   prod_ff, prod_in;
         logic [31:0]   val1_ff, val2_ff;
         logic [QW-1:0] quot;
         logic [31:0]   qm_ff, qm_in;
         logic [31:0]   diff;
         logic [AW:0]   rem;
         logic [AW:0]   rem_fix;

         always_comb begin
            prod_in = 64'(value) * 64'(RECIP);
            quot    = prod_ff[63:SHIFT];
            qm_in   = 32'(64'(quot) * 64'(MODULUS));
            diff    = val2_ff - qm_ff;
            rem     = diff[AW:0];
            rem_fix = (rem >= (AW+1)'(MODULUS)) ? rem - (AW+1)'(MODULUS) : rem;
         end

         always_ff @(posedge clock) begin
            prod_ff <= prod_in;
            val1_ff <= value;
            qm_ff   <= qm_in;
            val2_ff <= val1_ff;
            res_ff  <= rem_fix[AW-1:0];
         end
      end
   endgenerate

   assign done   = v3_ff;
   assign result = res_ff;

endmodule

@@ rtl/msd_alu.sv @@
// B bus selection, 32-bit ALU and shifter for one microinstruction.
module msd_alu import msd_pkg::*; (
   input  mir_type       mir,
   input  word_regs_type regs,
   input  logic [7:0]    mbr,
   output logic [31:0]   result,
   output logic [1:0]    flags
);

   logic [31:0] bbus;
   logic [31:0] a_op;
   logic [31:0] b_op;
   logic [31:0] raw;

   always_comb begin
      unique case (mir.bsel)
         BSRC_MDR:  bbus = regs[IDX_MDR];
         BSRC_PC:   bbus = regs[IDX_PC];
         BSRC_MBRS: bbus = {{24{mbr[7]}}, mbr};
         BSRC_MBRU: bbus = {24'b0, mbr};
         BSRC_SP:   bbus = regs[IDX_SP];
         BSRC_LV:   bbus = regs[IDX_LV];
         BSRC_CPP:  bbus = regs[IDX_CPP];
         BSRC_TOS:  bbus = regs[IDX_TOS];
         BSRC_OPC:  bbus = regs[IDX_OPC];
         default:   bbus = 32'b0;
      endcase

      // control bits: F0 F1 ENA ENB INVA INC
      a_op = mir.alu[3] ? regs[IDX_H] : 32'b0;
      if (mir.alu[1]) begin
         a_op = ~a_op;
      end
      b_op = mir.alu[2] ? bbus : 32'b0;

      unique case (mir.alu[5:4])
         FN_AND:  raw = a_op & b_op;
         FN_OR:   raw = a_op | b_op;
         FN_NOTB: raw = ~b_op;
         default: raw = a_op + b_op + {31'b0, mir.alu[0]};
      endcase

      // bit0 set on a zero result, bit1 otherwise
      flags = (raw == 32'b0) ? 2'b01 : 2'b10;

      unique case (mir.shift)
         SH_SLL8: result = {raw[23:0], 8'b0};
         SH_SRA1: result = {raw[31], raw[31:1]};
         default: result = raw;
      endcase
   end

endmodule
